/* rtl/lgu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lgu_pkg
// Shared types and constants for the loss and gradient unit.
// ----------------------------------------------------------------------------
package lgu_pkg;

   localparam int ACC_BITS    = 40;
   localparam int OUT_BITS    = 40;
   localparam logic [16:0] ONE_Q15 = 17'd32768;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   localparam logic [25:0] PENALTY_RESET = 26'd46425466;

   localparam logic CSR_MODE    = 1'b0;
   localparam logic CSR_PENALTY = 1'b1;

   localparam logic MODE_SQE = 1'b0;
   localparam logic MODE_BCE = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic load;       // capture item, clamp inputs
      logic sqe;        // compute squared error result
      logic div_start;  // start both quotient divisions
      logic div_step;   // one restoring step on both dividers
      logic grad_done;  // form bce gradient
      logic ln_start;   // load log unit with operand
      logic ln_sel;     // 0: log of p, 1: log of q
      logic ln_step;    // one squaring step
      logic ln_mul;     // scale log2 by ln2
      logic ln_acc;     // multiply log by weight and add to loss sum
      logic loss_fin;   // shift loss sum into element loss
      logic emit;       // load output register
   } lgu_cmd_type;

   typedef struct packed {
      logic bce;
      logic right;
      logic wrong;
   } lgu_sts_type;

endpackage
`default_nettype wire

/* rtl/loss_and_gradient_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// loss_and_gradient_unit
// Per-element loss gradient and per-vector summed loss, two loss modes.
// ----------------------------------------------------------------------------
// One element at a time. A squared error element, or a confidently right
// cross-entropy element, passes through decode, the loss step and the emit.
// A general cross-entropy element takes one decode state, 33 steps of a
// radix-2 divider pair for the gradient, one gradient state, then two log
// evaluations (load, 16 squaring steps, ln2 scale, weighted add), the loss
// step and the emit. The next element is accepted once the unit is idle.
// A confidently wrong element skips the logs. The result sits in an output
// register so the next element is accepted while it waits; an element that
// finishes while the previous result is still untaken waits in its last state.
module loss_and_gradient_unit import lgu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // prediction[15:0], target[31:16]
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // gradient[31:0], loss_total[71:32]
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [25:0] csr_data
);

   logic        mode_ff;
   logic [25:0] pen_ff;
   logic        busy, full, req_fire;
   lgu_cmd_type cmd;
   lgu_sts_type sts;
   logic [31:0] grad;
   logic [OUT_BITS-1:0] tot;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SQE;
         pen_ff  <= PENALTY_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_MODE) mode_ff <= csr_data[0];
         else                       pen_ff  <= csr_data;
      end
   end

   assign req_tready = !busy;
   assign req_fire   = req_tvalid && req_tready;

   lgu_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire),
      .out_free(!full || rsp_tready), .sts(sts), .busy(busy), .cmd(cmd)
   );

   lgu_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .prediction(req_tdata[15:0]), .target(req_tdata[31:16]), .last(req_tlast),
      .loss_mode(mode_ff), .edge_penalty(pen_ff),
      .rsp_take(rsp_tready), .rsp_full(full),
      .gradient(grad), .loss_total(tot), .last_out(rsp_tlast)
   );

   assign rsp_tvalid = full;
   assign rsp_tdata  = {tot, grad};

endmodule
`default_nettype wire

/* rtl/lgu_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lgu_ctrl
// Sequencer for one element: decode, divide and two logs for cross-entropy, loss, emit.
// ----------------------------------------------------------------------------
module lgu_ctrl import lgu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_fire,
   input  wire logic        out_free,
   input  wire lgu_sts_type sts,
   output logic             busy,
   output lgu_cmd_type      cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_DIV, ST_GRAD, ST_LNP_INIT, ST_LNP_SQ, ST_LNP_MUL,
      ST_LNP_ACC, ST_LNQ_INIT, ST_LNQ_SQ, ST_LNQ_MUL, ST_LNQ_ACC, ST_FIN, ST_EMIT
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!sts.bce) begin
               cmd.sqe  = 1'b1;
               state_in = ST_FIN;
            end else if (sts.right) begin
               state_in = ST_FIN;
            end else begin
               cmd.div_start = 1'b1;
               cnt_in   = 6'd0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd32) state_in = ST_GRAD;
         end
         ST_GRAD: begin
            cmd.grad_done = 1'b1;
            state_in = sts.wrong ? ST_FIN : ST_LNP_INIT;
         end
         ST_LNP_INIT: begin
            cmd.ln_start = 1'b1;
            cnt_in   = 6'd0;
            state_in = ST_LNP_SQ;
         end
         ST_LNP_SQ: begin
            cmd.ln_step = 1'b1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd15) state_in = ST_LNP_MUL;
         end
         ST_LNP_MUL: begin
            cmd.ln_mul = 1'b1;
            state_in = ST_LNP_ACC;
         end
         ST_LNP_ACC: begin
            cmd.ln_acc = 1'b1;
            state_in = ST_LNQ_INIT;
         end
         ST_LNQ_INIT: begin
            cmd.ln_start = 1'b1;
            cmd.ln_sel   = 1'b1;
            cnt_in   = 6'd0;
            state_in = ST_LNQ_SQ;
         end
         ST_LNQ_SQ: begin
            cmd.ln_step = 1'b1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd15) state_in = ST_LNQ_MUL;
         end
         ST_LNQ_MUL: begin
            cmd.ln_mul = 1'b1;
            state_in = ST_LNQ_ACC;
         end
         ST_LNQ_ACC: begin
            cmd.ln_acc = 1'b1;
            cmd.ln_sel = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.loss_fin = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule
`default_nettype wire

/* rtl/lgu_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lgu_datapath
// Clamp, dividers, log unit, loss accumulator and result register.
// ----------------------------------------------------------------------------
module lgu_datapath import lgu_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lgu_cmd_type        cmd,
   output lgu_sts_type             sts,
   input  wire logic [15:0]        prediction,
   input  wire logic [15:0]        target,
   input  wire logic               last,
   input  wire logic               loss_mode,
   input  wire logic [25:0]        edge_penalty,
   input  wire logic               rsp_take,
   output logic                    rsp_full,
   output logic [31:0]             gradient,
   output logic [OUT_BITS-1:0]     loss_total,
   output logic                    last_out
);

   logic [16:0] p_ff, t_ff;
   logic        last_ff, mode_ff;
   logic [16:0] p_c, t_c, q_w, u_w;
   logic [31:0] grad_ff;
   logic [47:0] lsum_ff;     // t*nl(p) + u*nl(q), before >>15
   logic [25:0] loss_ff;     // element loss
   logic [ACC_BITS-1:0] acc_ff;

   assign p_c = (prediction > 16'd32768) ? ONE_Q15 : {1'b0, prediction};
   assign t_c = (target > 16'd32768) ? ONE_Q15 : {1'b0, target};
   assign q_w = ONE_Q15 - p_ff;
   assign u_w = ONE_Q15 - t_ff;

   assign sts.bce   = mode_ff == MODE_BCE;
   assign sts.right = (t_ff == 17'd0 && p_ff == 17'd0) ||
                      (t_ff == ONE_Q15 && p_ff == ONE_Q15);
   assign sts.wrong = (t_ff == 17'd0 && p_ff == ONE_Q15) ||
                      (t_ff == ONE_Q15 && p_ff == 17'd0);

   // two restoring dividers, one quotient bit per step
   logic [32:0] ln_num_ff, rn_num_ff;
   logic [33:0] ln_rem_ff, rn_rem_ff;
   logic [16:0] ln_den_ff, rn_den_ff;
   logic [33:0] ln_sh, rn_sh;
   logic [34:0] ln_df, rn_df;
   assign ln_sh = {ln_rem_ff[32:0], ln_num_ff[32]};
   assign rn_sh = {rn_rem_ff[32:0], rn_num_ff[32]};
   assign ln_df = {1'b0, ln_sh} - {18'd0, ln_den_ff};
   assign rn_df = {1'b0, rn_sh} - {18'd0, rn_den_ff};

   // log unit
   logic [16:0] lx;
   logic [4:0]  lz;
   logic [31:0] z_ff;
   logic [15:0] frac_ff;
   logic [4:0]  sh_ff;
   logic [63:0] zz;
   logic [33:0] zn;
   logic [20:0] n_w;
   logic [31:0] nl_ff;
   logic [52:0] nl_prod;
   logic [16:0] wt;

   assign lx = cmd.ln_sel ? ((q_w == 17'd0) ? 17'd1 : q_w)
                          : ((p_ff == 17'd0) ? 17'd1 : p_ff);
   always_comb begin
      lz = 5'd0;
      for (int i = 15; i >= 0; i--) begin
         if (lx[i] && lz == 5'd0 && lx[16] == 1'b0) lz = 5'd15 - 5'(i);
      end
      if (lx[16] || lx[15]) lz = 5'd0;
   end
   assign zz = {32'd0, z_ff} * {32'd0, z_ff};
   assign zn = zz[63:30];
   assign n_w = {sh_ff, 16'd0} - {5'd0, frac_ff};
   assign nl_prod = {32'd0, n_w} * {21'd0, LN2_Q32} + 53'h80000000;
   assign wt = cmd.ln_sel ? u_w : t_ff;

   logic signed [34:0] gdiff;
   assign gdiff = $signed({2'b00, rn_num_ff}) - $signed({2'b00, ln_num_ff});

   logic [ACC_BITS:0] acc_sum;
   assign acc_sum = {1'b0, acc_ff} + {{(ACC_BITS-25){1'b0}}, loss_ff};

   logic [ACC_BITS-1:0] acc_new;
   assign acc_new = acc_sum[ACC_BITS] ? {ACC_BITS{1'b1}} : acc_sum[ACC_BITS-1:0];

   logic [31:0] grad_o_ff;
   logic [OUT_BITS-1:0] tot_ff;
   logic lasto_ff, full_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         p_ff    <= p_c;
         t_ff    <= t_c;
         last_ff <= last;
         mode_ff <= loss_mode;
         grad_ff <= '0;
         loss_ff <= '0;
         lsum_ff <= '0;
      end
      if (cmd.sqe) begin
         logic signed [17:0] d;
         logic [16:0] ad;
         logic [33:0] sq;
         d  = $signed({1'b0, p_ff}) - $signed({1'b0, t_ff});
         ad = d[17] ? 17'(-d) : d[16:0];
         sq = {17'd0, ad} * {17'd0, ad};
         grad_ff <= {{13{d[17]}}, d, 1'b0};
         loss_ff <= 26'(sq >> 15);
      end
      if (cmd.div_start) begin
         ln_num_ff <= {t_ff, 16'd0};
         rn_num_ff <= {u_w, 16'd0};
         ln_den_ff <= (p_ff == 17'd0) ? 17'd1 : p_ff;
         rn_den_ff <= (q_w == 17'd0) ? 17'd1 : q_w;
         ln_rem_ff <= '0;
         rn_rem_ff <= '0;
      end
      if (cmd.div_step) begin
         // quotient bits shift into the numerator register
         if (!ln_df[34]) begin
            ln_rem_ff <= ln_df[33:0];
            ln_num_ff <= {ln_num_ff[31:0], 1'b1};
         end else begin
            ln_rem_ff <= ln_sh;
            ln_num_ff <= {ln_num_ff[31:0], 1'b0};
         end
         if (!rn_df[34]) begin
            rn_rem_ff <= rn_df[33:0];
            rn_num_ff <= {rn_num_ff[31:0], 1'b1};
         end else begin
            rn_rem_ff <= rn_sh;
            rn_num_ff <= {rn_num_ff[31:0], 1'b0};
         end
      end
      if (cmd.grad_done) begin
         if (gdiff > 35'sd2147483647)       grad_ff <= 32'h7FFFFFFF;
         else if (gdiff < -35'sd2147483648) grad_ff <= 32'h80000000;
         else                               grad_ff <= gdiff[31:0];
         if (sts.wrong) loss_ff <= edge_penalty;
      end
      if (cmd.ln_start) begin
         z_ff    <= 32'({15'd0, lx << lz} << 15);
         sh_ff   <= lz;
         frac_ff <= '0;
      end
      if (cmd.ln_step) begin
         if (zn[31] || zn[33:32] != 2'd0) begin
            z_ff    <= zn[32:1];
            frac_ff <= {frac_ff[14:0], 1'b1};
         end else begin
            z_ff    <= zn[31:0];
            frac_ff <= {frac_ff[14:0], 1'b0};
         end
      end
      if (cmd.ln_mul) nl_ff <= nl_prod[52:32] == 21'd0 ? 32'd0 : 32'(nl_prod >> 32);
      if (cmd.ln_acc) lsum_ff <= lsum_ff + 48'({31'd0, wt} * {16'd0, nl_ff});
      if (cmd.loss_fin) begin
         if (mode_ff == MODE_BCE && !sts.right && !sts.wrong)
            loss_ff <= 26'(lsum_ff >> 15);
      end
      if (cmd.emit) begin
         grad_o_ff <= grad_ff;
         lasto_ff  <= last_ff;
         tot_ff    <= last_ff ? acc_new : '0;
      end
   end

   // accumulator is applied at emit
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         full_ff <= 1'b0;
      end else begin
         if (cmd.emit) acc_ff <= last_ff ? '0 : acc_new;
         if (cmd.emit)      full_ff <= 1'b1;
         else if (rsp_take) full_ff <= 1'b0;
      end
   end

   assign rsp_full   = full_ff;
   assign gradient   = grad_o_ff;
   assign loss_total = tot_ff;
   assign last_out   = lasto_ff;

endmodule
`default_nettype wire

/* rtl/lgu_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lgu_checker
// Port-level checks for the loss and gradient unit.
// ----------------------------------------------------------------------------
module lgu_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [71:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   // one element in flight: busy right after a transaction
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("accepted twice");

   // loss total only shown on the last element
   a_tot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[71:32] == 40'd0)
      else $error("loss total outside last");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");

   // no result without a prior accepted transaction
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("spurious result");

endmodule

bind loss_and_gradient_unit lgu_checker u_lgu_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast)
);
`default_nettype wire
